/* rtl/core/v3n_pkg.sv */
// shared types and constants for the vector normalizer
`default_nettype none
package v3n_pkg;
	localparam int CompW = 16;
	localparam int MagW = 16;
	localparam int SqW = 32;
	localparam int LenW = 16;
	localparam int FracBits = 14;
	localparam int UnitW = 16;
	localparam int QuoW = MagW + FracBits + 1;
	localparam int RootSteps = 16;
	localparam int DivSteps = QuoW;

	typedef struct packed {
		logic signed [CompW-1:0] comp_x;
		logic signed [CompW-1:0] comp_y;
		logic signed [CompW-1:0] comp_z;
	} vec_in_t;

	typedef struct packed {
		logic signed [UnitW-1:0] unit_x;
		logic signed [UnitW-1:0] unit_y;
		logic signed [UnitW-1:0] unit_z;
		logic [SqW-1:0] squared_length;
		logic [LenW-1:0] vector_length;
		logic is_zero;
	} vec_out_t;

	typedef struct packed {
		logic [2:0] neg;
		logic [MagW-1:0] mag_x;
		logic [MagW-1:0] mag_y;
		logic [MagW-1:0] mag_z;
		logic [SqW-1:0] sq;
	} sq_res_t;
endpackage
`default_nettype wire

/* rtl/core/v3n_if.sv */
// valid/ready channel interfaces
`default_nettype none
interface v3n_in_if (input wire logic clk);
	logic valid;
	logic ready;
	v3n_pkg::vec_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface v3n_out_if (input wire logic clk);
	logic valid;
	logic ready;
	v3n_pkg::vec_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/vector3_normalize_top.sv */
// top level of the three-component vector normalizer
// pipeline: sum-of-squares stages, root stages and divide stages, then the output register
// throughput: one beat per cycle while the output is not stalled, set by the fully pipelined root and divide stages
// a stall freezes the whole pipeline; bubbles already inside stay in place
// reset clears all valid bits; payload registers are not reset
`default_nettype none
module vector3_normalize_top (
	input wire logic clk,
	input wire logic arst_n,
	v3n_in_if.sink in_ch,
	v3n_out_if.source out_ch
);
	logic adv, v2, vr, vd;
	v3n_pkg::sq_res_t r2, rr;
	logic [v3n_pkg::LenW-1:0] root;
	v3n_pkg::vec_out_t dd;
	logic oval_q;
	v3n_pkg::vec_out_t odat_q;

	assign adv = !oval_q || out_ch.ready;
	assign in_ch.ready = adv;

	v3n_sumsq u_sumsq (.clk, .arst_n, .adv, .in_valid(in_ch.valid), .in_data(in_ch.data),
		.valid_s2(v2), .res_s2(r2));
	v3n_sqrt u_sqrt (.clk, .arst_n, .adv, .in_valid(v2), .in_res(r2), .out_valid(vr),
		.out_res(rr), .out_root(root));
	v3n_div u_div (.clk, .arst_n, .adv, .in_valid(vr), .in_res(rr), .in_root(root),
		.out_valid(vd), .out_data(dd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (adv) begin
			oval_q <= vd;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			odat_q <= dd;
		end
	end

	assign out_ch.valid = oval_q;
	assign out_ch.data = odat_q;

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		oval_q |-> (odat_q.is_zero == (odat_q.vector_length == '0)))
		else $error("zero flag and length disagree");
	a_zero_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(oval_q && odat_q.is_zero) |-> (odat_q.unit_x == '0 && odat_q.unit_y == '0
		&& odat_q.unit_z == '0))
		else $error("zero vector gave nonzero unit");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(oval_q && !out_ch.ready) |=> (oval_q && $stable(odat_q)))
		else $error("output beat lost during stall");
endmodule
`default_nettype wire

/* rtl/core/v3n_sumsq.sv */
// magnitudes and registered sum of squares
`default_nettype none
module v3n_sumsq (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic in_valid,
	input wire v3n_pkg::vec_in_t in_data,
	output logic valid_s2,
	output v3n_pkg::sq_res_t res_s2
);
	logic valid_s1;
	logic [2:0] neg_s1;
	logic [v3n_pkg::MagW-1:0] mx_s1, my_s1, mz_s1;
	logic [v3n_pkg::SqW-1:0] px_s1, py_s1, pz_s1;
	logic [v3n_pkg::MagW-1:0] mx, my, mz;

	assign mx = in_data.comp_x[v3n_pkg::CompW-1] ? v3n_pkg::MagW'(-in_data.comp_x)
		: v3n_pkg::MagW'(in_data.comp_x);
	assign my = in_data.comp_y[v3n_pkg::CompW-1] ? v3n_pkg::MagW'(-in_data.comp_y)
		: v3n_pkg::MagW'(in_data.comp_y);
	assign mz = in_data.comp_z[v3n_pkg::CompW-1] ? v3n_pkg::MagW'(-in_data.comp_z)
		: v3n_pkg::MagW'(in_data.comp_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= {in_data.comp_x[v3n_pkg::CompW-1], in_data.comp_y[v3n_pkg::CompW-1],
				in_data.comp_z[v3n_pkg::CompW-1]};
			mx_s1 <= mx;
			my_s1 <= my;
			mz_s1 <= mz;
			px_s1 <= mx * mx;
			py_s1 <= my * my;
			pz_s1 <= mz * mz;
			res_s2.neg <= neg_s1;
			res_s2.mag_x <= mx_s1;
			res_s2.mag_y <= my_s1;
			res_s2.mag_z <= mz_s1;
			res_s2.sq <= px_s1 + py_s1 + pz_s1;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/v3n_sqrt.sv */
// pipelined floor square root, one result bit per stage
`default_nettype none
module v3n_sqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic in_valid,
	input wire v3n_pkg::sq_res_t in_res,
	output logic out_valid,
	output v3n_pkg::sq_res_t out_res,
	output logic [v3n_pkg::LenW-1:0] out_root
);
	localparam int N = v3n_pkg::RootSteps;
	logic [N:0] vld;
	v3n_pkg::sq_res_t res [N+1];
	logic [v3n_pkg::SqW-1:0] rem [N+1];
	logic [v3n_pkg::LenW-1:0] root [N+1];

	assign vld[0] = in_valid;
	assign res[0] = in_res;
	assign rem[0] = in_res.sq;
	assign root[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam int Sh = 2 * (N - 1 - i);
		logic [v3n_pkg::SqW+1:0] trial;
		logic [v3n_pkg::SqW+1:0] top;
		logic [v3n_pkg::LenW-1:0] rn;
		logic [v3n_pkg::SqW-1:0] remn;
		always_comb begin
			top = {2'b00, rem[i]} >> Sh;
			trial = {root[i], 2'b01};
			rn = {root[i][v3n_pkg::LenW-2:0], 1'b0};
			remn = rem[i];
			if (top >= trial) begin
				remn = rem[i] - v3n_pkg::SqW'(trial << Sh);
				rn = {root[i][v3n_pkg::LenW-2:0], 1'b1};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else if (adv) begin
				vld[i+1] <= vld[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				res[i+1] <= res[i];
				rem[i+1] <= remn;
				root[i+1] <= rn;
			end
		end
	end

	assign out_valid = vld[N];
	assign out_res = res[N];
	assign out_root = root[N];
endmodule
`default_nettype wire

/* rtl/core/v3n_div.sv */
// pipelined restoring divide of three magnitudes by the length
`default_nettype none
module v3n_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic in_valid,
	input wire v3n_pkg::sq_res_t in_res,
	input wire logic [v3n_pkg::LenW-1:0] in_root,
	output logic out_valid,
	output v3n_pkg::vec_out_t out_data
);
	localparam int N = v3n_pkg::DivSteps;
	localparam int W = v3n_pkg::QuoW;
	localparam int RW = v3n_pkg::LenW + 1;
	logic [N:0] vld;
	v3n_pkg::sq_res_t res [N+1];
	logic [v3n_pkg::LenW-1:0] den [N+1];
	logic [W-1:0] num [N+1][3];
	logic [RW-1:0] rem [N+1][3];

	assign vld[0] = in_valid;
	assign res[0] = in_res;
	assign den[0] = in_root;
	assign num[0][0] = W'({in_res.mag_x, {v3n_pkg::FracBits{1'b0}}});
	assign num[0][1] = W'({in_res.mag_y, {v3n_pkg::FracBits{1'b0}}});
	assign num[0][2] = W'({in_res.mag_z, {v3n_pkg::FracBits{1'b0}}});
	for (genvar k = 0; k < 3; k++) begin : g_r0
		assign rem[0][k] = '0;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [W-1:0] nn [3];
		logic [RW-1:0] rn [3];
		always_comb begin
			for (int k = 0; k < 3; k++) begin
				rn[k] = {rem[i][k][RW-2:0], num[i][k][W-1]};
				nn[k] = {num[i][k][W-2:0], 1'b0};
				if (rn[k] >= {1'b0, den[i]}) begin
					rn[k] = rn[k] - {1'b0, den[i]};
					nn[k][0] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else if (adv) begin
				vld[i+1] <= vld[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				res[i+1] <= res[i];
				den[i+1] <= den[i];
				for (int k = 0; k < 3; k++) begin
					num[i+1][k] <= nn[k];
					rem[i+1][k] <= rn[k];
				end
			end
		end
	end

	logic zero;
	logic [v3n_pkg::UnitW-1:0] q [3];
	assign zero = (res[N].sq == '0);
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			q[k] = zero ? '0 : num[N][k][v3n_pkg::UnitW-1:0];
		end
	end

	assign out_valid = vld[N];
	assign out_data.unit_x = res[N].neg[2] ? -q[0] : q[0];
	assign out_data.unit_y = res[N].neg[1] ? -q[1] : q[1];
	assign out_data.unit_z = res[N].neg[0] ? -q[2] : q[2];
	assign out_data.squared_length = res[N].sq;
	assign out_data.vector_length = den[N];
	assign out_data.is_zero = zero;
endmodule
`default_nettype wire
